// ----- src/point_bounding_box_centroid_unit_assert.svh -----
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef POINT_BOUNDING_BOX_CENTROID_UNIT_ASSERT_SVH
`define POINT_BOUNDING_BOX_CENTROID_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PBBC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PBBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pbbc_pkg.sv -----
`default_nettype none

package pbbc_pkg;

	localparam int MAX_POINTS_DEF  = 65536;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int TOTAL_W         = 17;
	// sums are held in at most this many bits and wrap beyond it
	localparam int SUM_MAX_W       = 64;

	typedef struct packed {
		logic accum;     // point transfer: update extremes, sum, count
		logic div_load;  // load dividers from the running sums
		logic div_step;  // one quotient bit per divider
		logic out_load;  // capture result, rearm the count
	} cmd_t;

endpackage

`default_nettype wire

// ----- src/point_bounding_box_centroid_unit.sv -----
// Channel   Handshake             Payload
// points    in_valid / in_ready   x_coord, y_coord, z_coord, last_point
// result    out_valid / out_ready mean_x..z, lowest/highest_x..z, point_total,
//                                 count_overflow
//
// Points are taken one per cycle. After the last point of a cloud, input stalls while
// the controller runs a load step, SUM_W steps of the three bit-serial dividers and a
// step that writes the result register.
// If the previous result is still waiting at that point, the block holds until it is taken.
// Reset clears the controller, the point count and its overflow flag only; no clearing pass is needed.
`default_nettype none

module point_bounding_box_centroid_unit #(
	parameter int MAX_POINTS  = pbbc_pkg::MAX_POINTS_DEF,
	parameter int COORD_WIDTH = pbbc_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] x_coord,
	input  wire logic signed [COORD_WIDTH-1:0] y_coord,
	input  wire logic signed [COORD_WIDTH-1:0] z_coord,
	input  wire logic                          last_point,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      mean_x,
	output logic signed [COORD_WIDTH-1:0]      mean_y,
	output logic signed [COORD_WIDTH-1:0]      mean_z,
	output logic signed [COORD_WIDTH-1:0]      lowest_x,
	output logic signed [COORD_WIDTH-1:0]      highest_x,
	output logic signed [COORD_WIDTH-1:0]      lowest_y,
	output logic signed [COORD_WIDTH-1:0]      highest_y,
	output logic signed [COORD_WIDTH-1:0]      lowest_z,
	output logic signed [COORD_WIDTH-1:0]      highest_z,
	output logic [pbbc_pkg::TOTAL_W-1:0]       point_total,
	output logic                               count_overflow
);

	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int SUM_RAW = COORD_WIDTH + CNT_W;
	localparam int SUM_W   = (SUM_RAW > pbbc_pkg::SUM_MAX_W) ? pbbc_pkg::SUM_MAX_W : SUM_RAW;

	pbbc_pkg::cmd_t cmd;

	pbbc_ctrl #(
		.SUM_W(SUM_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_point(last_point),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	pbbc_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_WIDTH(COORD_WIDTH),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.z_coord       (z_coord),
		.mean_x        (mean_x),
		.mean_y        (mean_y),
		.mean_z        (mean_z),
		.lowest_x      (lowest_x),
		.highest_x     (highest_x),
		.lowest_y      (lowest_y),
		.highest_y     (highest_y),
		.lowest_z      (lowest_z),
		.highest_z     (highest_z),
		.point_total   (point_total),
		.count_overflow(count_overflow)
	);

`include "point_bounding_box_centroid_unit_assert.svh"

	`PBBC_ASSERT_NEXT(a_stall_after_last, in_valid && in_ready && last_point, !in_ready, "point taken right after last point")
	`PBBC_ASSERT_IMP(a_result_after_divide, $rose(out_valid), $past(!in_ready), "result appeared without a divide")
	`PBBC_ASSERT_IMP(a_box_ordered, $rose(out_valid), (lowest_x <= highest_x) && (lowest_y <= highest_y) && (lowest_z <= highest_z), "bounding box inverted")

endmodule

`default_nettype wire

// ----- src/pbbc_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per step: mean = sum / divisor, toward zero.
module pbbc_div #(
	parameter int SUM_W       = 49,
	parameter int CNT_W       = 17,
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   load,
	input  wire logic                   step,
	input  wire logic [SUM_W-1:0]       sum,
	input  wire logic [CNT_W-1:0]       divisor,
	output logic      [COORD_WIDTH-1:0] mean
);

	logic                   neg_q;
	logic [SUM_W-1:0]       quo_q;
	logic [CNT_W-1:0]       rem_q;
	logic [CNT_W:0]         trial;
	logic                   take;
	logic [COORD_WIDTH-1:0] mag;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign take  = trial >= {1'b0, divisor};
	assign mag   = quo_q[COORD_WIDTH-1:0];
	assign mean  = neg_q ? (~mag + COORD_WIDTH'(1)) : mag;

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= sum[SUM_W-1];
			// magnitude of the most negative sum is still correct as unsigned
			quo_q <= sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
			rem_q <= '0;
		end else if (step) begin
			quo_q <= {quo_q[SUM_W-2:0], take};
			rem_q <= take ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- src/pbbc_ctrl.sv -----
`default_nettype none

module pbbc_ctrl #(
	parameter int SUM_W = 49
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            last_point,
	input  wire logic            out_ready,
	output logic                 in_ready,
	output logic                 out_valid,
	output pbbc_pkg::cmd_t       cmd
);

	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	typedef enum logic [3:0] {
		ST_ACCUM  = 4'b0001,
		ST_LOAD   = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic                rdy;

	assign in_ready  = rdy;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		rdy     = 1'b0;
		case (state_q)
			ST_ACCUM: begin
				rdy = 1'b1;
				if (in_valid) begin
					cmd.accum = 1'b1;
					if (last_point) state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == LAST_STEP) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// output register free or being emptied this cycle
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACCUM;
				end
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_load) step_q <= '0;
			else if (cmd.div_step) step_q <= step_q + STEP_W'(1);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- src/pbbc_dp.sv -----
`default_nettype none

module pbbc_dp #(
	parameter int MAX_POINTS  = 65536,
	parameter int COORD_WIDTH = 32,
	parameter int CNT_W       = 17,
	parameter int SUM_W       = 49
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pbbc_pkg::cmd_t                cmd,
	input  wire logic signed [COORD_WIDTH-1:0] x_coord,
	input  wire logic signed [COORD_WIDTH-1:0] y_coord,
	input  wire logic signed [COORD_WIDTH-1:0] z_coord,
	output logic signed [COORD_WIDTH-1:0]      mean_x,
	output logic signed [COORD_WIDTH-1:0]      mean_y,
	output logic signed [COORD_WIDTH-1:0]      mean_z,
	output logic signed [COORD_WIDTH-1:0]      lowest_x,
	output logic signed [COORD_WIDTH-1:0]      highest_x,
	output logic signed [COORD_WIDTH-1:0]      lowest_y,
	output logic signed [COORD_WIDTH-1:0]      highest_y,
	output logic signed [COORD_WIDTH-1:0]      lowest_z,
	output logic signed [COORD_WIDTH-1:0]      highest_z,
	output logic [pbbc_pkg::TOTAL_W-1:0]       point_total,
	output logic                               count_overflow
);

	localparam int TW = pbbc_pkg::TOTAL_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

	logic signed [COORD_WIDTH-1:0] coord [3];
	logic signed [COORD_WIDTH-1:0] min_q [3];
	logic signed [COORD_WIDTH-1:0] max_q [3];
	logic signed [SUM_W-1:0]       sum_q [3];
	logic        [COORD_WIDTH-1:0] mean_w [3];
	logic signed [COORD_WIDTH-1:0] mean_q [3];
	logic signed [COORD_WIDTH-1:0] low_q [3];
	logic signed [COORD_WIDTH-1:0] high_q [3];

	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [TW-1:0]    total_q;
	logic             ovf_out_q;
	logic             first;
	logic             room;

	assign coord[0] = x_coord;
	assign coord[1] = y_coord;
	assign coord[2] = z_coord;

	// a zero count means the next point opens a cloud
	assign first = cnt_q == '0;
	assign room  = cnt_q < CNT_MAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.out_load) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.accum) begin
			if (first) begin
				cnt_q <= CNT_W'(1);
				ovf_q <= 1'b0;
			end else if (room) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		always_ff @(posedge clk) begin
			if (cmd.accum) begin
				if (first) begin
					min_q[a] <= coord[a];
					max_q[a] <= coord[a];
					sum_q[a] <= SUM_W'(coord[a]);
				end else begin
					if (coord[a] < min_q[a]) min_q[a] <= coord[a];
					if (coord[a] > max_q[a]) max_q[a] <= coord[a];
					// points past the bound still widen the box
					if (room) sum_q[a] <= sum_q[a] + SUM_W'(coord[a]);
				end
			end
		end

		pbbc_div #(
			.SUM_W      (SUM_W),
			.CNT_W      (CNT_W),
			.COORD_WIDTH(COORD_WIDTH)
		) u_div (
			.clk    (clk),
			.load   (cmd.div_load),
			.step   (cmd.div_step),
			.sum    (sum_q[a]),
			.divisor(cnt_q),
			.mean   (mean_w[a])
		);

		always_ff @(posedge clk) begin
			if (cmd.out_load) begin
				mean_q[a] <= mean_w[a];
				low_q[a]  <= min_q[a];
				high_q[a] <= max_q[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			total_q   <= TW'(cnt_q);
			ovf_out_q <= ovf_q;
		end
	end

	assign mean_x         = mean_q[0];
	assign mean_y         = mean_q[1];
	assign mean_z         = mean_q[2];
	assign lowest_x       = low_q[0];
	assign highest_x      = high_q[0];
	assign lowest_y       = low_q[1];
	assign highest_y      = high_q[1];
	assign lowest_z       = low_q[2];
	assign highest_z      = high_q[2];
	assign point_total    = total_q;
	assign count_overflow = ovf_out_q;

endmodule

`default_nettype wire
